@@ rtl/core/ogop_pkg.sv @@
`timescale 1ns / 1ps

package ogop_pkg;

  // Default map limits.
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;

  // Entries of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CODE_W    = 2;
  localparam int POS_W     = 5;
  localparam int LINE_W    = 2 * CODE_W;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 6'd20;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 6'd20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // Cell codes.
  localparam logic [CODE_W-1:0] CODE_FREE = 2'd0;
  localparam logic [CODE_W-1:0] CODE_OBST = 2'd1;
  localparam logic [CODE_W-1:0] CODE_PAD  = 2'd2;

  // Emission slots of one input cell, in raster order of the emitted cells.
  localparam int EMIT_N        = 4;
  localparam int EMIT_BEHIND   = 0;  // cell whose window just closed
  localparam int EMIT_ROW_END  = 1;  // last cell of the row above the last row
  localparam int EMIT_LAST_ROW = 2;  // previous cell of the last row
  localparam int EMIT_FINAL    = 3;  // the frame's last cell

  typedef struct packed {
    logic [EMIT_N-1:0] emit;
    logic              c0;
    logic              c_ge1;
    logic              c_ge2;
    logic              w_ge2;
    logic              r_ge1;
    logic              r_ge2;
    logic              r_ge3;
  } rec_flags_t;

  // One column of the 3x3 window: rows r-2, r-1 and r of the cell's column.
  typedef struct packed {
    logic [CODE_W-1:0] top;
    logic [CODE_W-1:0] mid;
    logic [CODE_W-1:0] bot;
  } col_vec_t;

endpackage

@@ rtl/core/occupancy_grid_obstacle_padding.sv @@
`timescale 1ns / 1ps
// Path: a result passes the queue, the back's cell register and the output register;
//   a cell is released width+1 cells later, a last-row cell one cell later.
// Throughput: one cell, one result transfer per cycle if unstalled; a last-row cell after the
//   first releases two results (the last cell four), so the last row runs at half rate.
// Reset: synchronous, active low; clears counters, queue and output valid, sets a 20x20 map.
//   The line buffer is not cleared: a row is read only after this frame has written it.

module occupancy_grid_obstacle_padding import ogop_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // raster cells in
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CODE_W-1:0]    in_cell_code,
  // padded cells out
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CODE_W-1:0]    out_padded_code,
  output logic [POS_W-1:0]     out_cell_column,
  output logic [POS_W-1:0]     out_cell_row,
  output logic                 out_frame_done
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Front to queue.
  logic              f_push;
  logic [CODE_W-1:0] f_code;
  logic [CW-1:0]     f_col;
  logic [RW-1:0]     f_row;
  logic [CW-1:0]     f_e1_col;
  logic [RW-1:0]     f_e1_row;
  rec_flags_t        f_flags;
  logic              q_full;

  // Queue to back.
  logic              q_valid;
  logic              q_pop;
  logic [CODE_W-1:0] q_code;
  logic [CW-1:0]     q_col;
  logic [RW-1:0]     q_row;
  logic [CW-1:0]     q_e1_col;
  logic [RW-1:0]     q_e1_row;
  rec_flags_t        q_flags;

  // Front: track the raster position, work out which cells each input
  // releases and the window edges that fall outside the map.
  ogop_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_code (in_cell_code),
    .q_full       (q_full),
    .q_push       (f_push),
    .q_code       (f_code),
    .q_col        (f_col),
    .q_row        (f_row),
    .q_e1_col     (f_e1_col),
    .q_e1_row     (f_e1_row),
    .q_flags      (f_flags)
  );

  // Queue: absorb the burst at the end of a frame and output stalls, so the
  // front keeps taking cells while the back drains.
  ogop_queue #(
    .COL_W (CW),
    .ROW_W (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (f_push),
    .push_code   (f_code),
    .push_col    (f_col),
    .push_row    (f_row),
    .push_e1_col (f_e1_col),
    .push_e1_row (f_e1_row),
    .push_flags  (f_flags),
    .full        (q_full),
    .pop         (q_pop),
    .head_valid  (q_valid),
    .head_code   (q_code),
    .head_col    (q_col),
    .head_row    (q_row),
    .head_e1_col (q_e1_col),
    .head_e1_row (q_e1_row),
    .head_flags  (q_flags)
  );

  // Back: read the two rows above from the line buffer, hold the last two
  // window columns, evaluate one window per cycle into the output register unless out_stall holds it.
  ogop_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_code          (q_code),
    .q_col           (q_col),
    .q_row           (q_row),
    .q_e1_col        (q_e1_col),
    .q_e1_row        (q_e1_row),
    .q_flags         (q_flags),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_padded_code (out_padded_code),
    .out_cell_column (out_cell_column),
    .out_cell_row    (out_cell_row),
    .out_frame_done  (out_frame_done)
  );

endmodule

@@ rtl/core/ogop_ram.sv @@
`timescale 1ns / 1ps

module ogop_ram import ogop_pkg::*; #(
  parameter int WIDTH = LINE_W,
  parameter int DEPTH = MAX_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ogop_front.sv @@
`timescale 1ns / 1ps

module ogop_front import ogop_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CODE_W-1:0]    in_cell_code,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [CODE_W-1:0]    q_code,
  output logic [CW-1:0]        q_col,
  output logic [RW-1:0]        q_row,
  output logic [CW-1:0]        q_e1_col,
  output logic [RW-1:0]        q_e1_row,
  output rec_flags_t           q_flags
);

  logic [CFG_W-1:0] grid_width_r;
  logic [CFG_W-1:0] grid_height_r;
  logic [CW-1:0]    in_col_r;
  logic [RW-1:0]    in_row_r;
  logic [CW-1:0]    col_last;
  logic [RW-1:0]    row_last;
  logic             accept;
  logic             last;
  rec_flags_t       flags;

  // Clamp the map size to 1..max and keep the last column and row.
  always_comb begin
    if (grid_width_r == '0) begin
      col_last = '0;
    end else if (int'(grid_width_r) > MAX_WIDTH) begin
      col_last = CW'(MAX_WIDTH - 1);
    end else begin
      col_last = CW'(grid_width_r - 6'd1);
    end
    if (grid_height_r == '0) begin
      row_last = '0;
    end else if (int'(grid_height_r) > MAX_HEIGHT) begin
      row_last = RW'(MAX_HEIGHT - 1);
    end else begin
      row_last = RW'(grid_height_r - 6'd1);
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign last     = (in_col_r == col_last) && (in_row_r == row_last);

  always_comb begin
    flags       = '0;
    flags.c0    = (in_col_r == '0);
    flags.c_ge1 = (in_col_r != '0);
    flags.c_ge2 = (int'(in_col_r) >= 2);
    flags.w_ge2 = (col_last != '0);
    flags.r_ge1 = (in_row_r != '0);
    flags.r_ge2 = (int'(in_row_r) >= 2);
    flags.r_ge3 = (int'(in_row_r) >= 3);
    flags.emit[EMIT_BEHIND]   = (flags.r_ge1 && flags.c_ge1) || (flags.c0 && flags.r_ge2);
    flags.emit[EMIT_ROW_END]  = last && (row_last != '0);
    flags.emit[EMIT_LAST_ROW] = (in_row_r == row_last) && flags.c_ge1;
    flags.emit[EMIT_FINAL]    = last;
  end

  // Cell that leaves behind the current one: up-left in the row above, or the
  // end of the row two above when the current cell opens a row.
  always_comb begin
    if (in_col_r != '0) begin
      q_e1_col = in_col_r - CW'(1);
      q_e1_row = in_row_r - RW'(1);
    end else begin
      q_e1_col = col_last;
      q_e1_row = in_row_r - RW'(1) - RW'(1);
    end
  end

  assign q_push  = accept;
  assign q_code  = in_cell_code;
  assign q_col   = in_col_r;
  assign q_row   = in_row_r;
  assign q_flags = flags;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      in_col_r      <= '0;
      in_row_r      <= '0;
    end else if (cfg_wr_en) begin
      // Restart the frame on any register write.
      case (cfg_index)
        REG_GRID_WIDTH: begin
          grid_width_r <= cfg_wdata;
          in_col_r     <= '0;
          in_row_r     <= '0;
        end
        REG_GRID_HEIGHT: begin
          grid_height_r <= cfg_wdata;
          in_col_r      <= '0;
          in_row_r      <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (last) begin
        in_col_r <= '0;
        in_row_r <= '0;
      end else if (in_col_r == col_last) begin
        in_col_r <= '0;
        in_row_r <= in_row_r + RW'(1);
      end else begin
        in_col_r <= in_col_r + CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/ogop_queue.sv @@
`timescale 1ns / 1ps

module ogop_queue import ogop_pkg::*; #(
  parameter int COL_W = POS_W,
  parameter int ROW_W = POS_W,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW   = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [CODE_W-1:0] push_code,
  input  logic [COL_W-1:0]  push_col,
  input  logic [ROW_W-1:0]  push_row,
  input  logic [COL_W-1:0]  push_e1_col,
  input  logic [ROW_W-1:0]  push_e1_row,
  input  rec_flags_t        push_flags,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [CODE_W-1:0] head_code,
  output logic [COL_W-1:0]  head_col,
  output logic [ROW_W-1:0]  head_row,
  output logic [COL_W-1:0]  head_e1_col,
  output logic [ROW_W-1:0]  head_e1_row,
  output rec_flags_t        head_flags
);

  logic [CODE_W-1:0] code_q   [DEPTH];
  logic [COL_W-1:0]  col_q    [DEPTH];
  logic [ROW_W-1:0]  row_q    [DEPTH];
  logic [COL_W-1:0]  e1_col_q [DEPTH];
  logic [ROW_W-1:0]  e1_row_q [DEPTH];
  rec_flags_t        flags_q  [DEPTH];

  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full        = (count_r == NW'(DEPTH));
  assign head_valid  = (count_r != '0);
  assign head_code   = code_q[rd_ptr_r];
  assign head_col    = col_q[rd_ptr_r];
  assign head_row    = row_q[rd_ptr_r];
  assign head_e1_col = e1_col_q[rd_ptr_r];
  assign head_e1_row = e1_row_q[rd_ptr_r];
  assign head_flags  = flags_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      code_q[wr_ptr_r]   <= push_code;
      col_q[wr_ptr_r]    <= push_col;
      row_q[wr_ptr_r]    <= push_row;
      e1_col_q[wr_ptr_r] <= push_e1_col;
      e1_row_q[wr_ptr_r] <= push_e1_row;
      flags_q[wr_ptr_r]  <= push_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

@@ rtl/core/ogop_back.sv @@
`timescale 1ns / 1ps

module ogop_back import ogop_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic [CODE_W-1:0] q_code,
  input  logic [CW-1:0]     q_col,
  input  logic [RW-1:0]     q_row,
  input  logic [CW-1:0]     q_e1_col,
  input  logic [RW-1:0]     q_e1_row,
  input  rec_flags_t        q_flags,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_padded_code,
  output logic [POS_W-1:0]  out_cell_column,
  output logic [POS_W-1:0]  out_cell_row,
  output logic              out_frame_done
);

  // Window rows are top/mid/bot, or mid/bot with no row below when lower.
  function automatic logic [CODE_W-1:0] win_eval(
    input col_vec_t l,
    input col_vec_t c,
    input col_vec_t r,
    input logic     lv,
    input logic     rv,
    input logic     lower,
    input logic     topv
  );
    logic [CODE_W-1:0] lt, lm, lb, ct, cm, cb, rt, rm, rb;
    logic              top_hit, mid_hit, bot_hit;
    lt = lower ? l.mid : l.top;
    lm = lower ? l.bot : l.mid;
    lb = l.bot;
    ct = lower ? c.mid : c.top;
    cm = lower ? c.bot : c.mid;
    cb = c.bot;
    rt = lower ? r.mid : r.top;
    rm = lower ? r.bot : r.mid;
    rb = r.bot;
    top_hit = topv && ((lv && lt == CODE_OBST) || ct == CODE_OBST || (rv && rt == CODE_OBST));
    mid_hit = (lv && lm == CODE_OBST) || (rv && rm == CODE_OBST);
    bot_hit = !lower && ((lv && lb == CODE_OBST) || cb == CODE_OBST ||
                         (rv && rb == CODE_OBST));
    if (cm == CODE_OBST || cm == CODE_PAD) begin
      return cm;
    end else if (top_hit || mid_hit || bot_hit) begin
      return CODE_PAD;
    end else begin
      return CODE_FREE;
    end
  endfunction

  logic              b_valid_r;
  logic [EMIT_N-1:0] pend_r;
  rec_flags_t        b_flags_r;
  logic [CODE_W-1:0] b_code_r;
  logic [CW-1:0]     b_col_r;
  logic [RW-1:0]     b_row_r;
  logic [CW-1:0]     b_e1_col_r;
  logic [RW-1:0]     b_e1_row_r;
  logic              fwd_hit_r;
  logic [LINE_W-1:0] fwd_data_r;
  col_vec_t          p1_r;
  col_vec_t          p2_r;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic [POS_W-1:0]  out_col_r;
  logic [POS_W-1:0]  out_row_r;
  logic              out_done_r;

  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line;
  logic [LINE_W-1:0] ram_wdata;
  col_vec_t          cur_vec;
  logic              emit_fire;
  logic [EMIT_N-1:0] pend_nxt;
  logic              b_leave;
  logic              b_take;

  col_vec_t          sel_l, sel_c, sel_r;
  logic              sel_lv, sel_rv, sel_lower, sel_topv, sel_done;
  logic [CW-1:0]     sel_col;
  logic [RW-1:0]     sel_row;
  logic [CODE_W-1:0] sel_code;

  // Two rows above the current cell, from the line buffer or forwarded.
  assign line        = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign cur_vec.top = line[LINE_W-1:CODE_W];
  assign cur_vec.mid = line[CODE_W-1:0];
  assign cur_vec.bot = b_code_r;
  assign ram_wdata   = {cur_vec.mid, b_code_r};

  assign emit_fire = b_valid_r && (pend_r != '0) && (!out_valid_r || !out_stall);
  assign pend_nxt  = emit_fire ? (pend_r & (pend_r - EMIT_N'(1))) : pend_r;
  assign b_leave   = b_valid_r && (pend_nxt == '0);
  assign b_take    = q_valid && (!b_valid_r || b_leave);
  assign q_pop     = b_take;

  // Pick the lowest pending emission and set up its window.
  always_comb begin
    sel_l     = p2_r;
    sel_c     = p1_r;
    sel_r     = cur_vec;
    sel_lv    = 1'b0;
    sel_rv    = 1'b0;
    sel_lower = 1'b0;
    sel_topv  = 1'b0;
    sel_done  = 1'b0;
    sel_col   = b_col_r;
    sel_row   = b_row_r;
    if (pend_r[EMIT_BEHIND]) begin
      sel_col = b_e1_col_r;
      sel_row = b_e1_row_r;
      if (b_flags_r.c0) begin
        sel_lv   = b_flags_r.w_ge2;
        sel_topv = b_flags_r.r_ge3;
      end else begin
        sel_lv   = b_flags_r.c_ge2;
        sel_rv   = 1'b1;
        sel_topv = b_flags_r.r_ge2;
      end
    end else if (pend_r[EMIT_ROW_END]) begin
      sel_l    = p1_r;
      sel_c    = cur_vec;
      sel_lv   = b_flags_r.c_ge1;
      sel_topv = b_flags_r.r_ge2;
      sel_row  = b_row_r - RW'(1);
    end else if (pend_r[EMIT_LAST_ROW]) begin
      sel_lv    = b_flags_r.c_ge2;
      sel_rv    = 1'b1;
      sel_lower = 1'b1;
      sel_topv  = b_flags_r.r_ge1;
      sel_col   = b_col_r - CW'(1);
    end else begin
      sel_l     = p1_r;
      sel_c     = cur_vec;
      sel_lv    = b_flags_r.c_ge1;
      sel_lower = 1'b1;
      sel_topv  = b_flags_r.r_ge1;
      sel_done  = 1'b1;
    end
    sel_code = win_eval(sel_l, sel_c, sel_r, sel_lv, sel_rv, sel_lower, sel_topv);
  end

  ogop_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (b_leave),
    .waddr (b_col_r),
    .wdata (ram_wdata),
    .re    (b_take),
    .raddr (q_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_take || (b_valid_r && !b_leave);
      pend_r      <= b_take ? q_flags.emit : pend_nxt;
      out_valid_r <= emit_fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      b_flags_r  <= q_flags;
      b_code_r   <= q_code;
      b_col_r    <= q_col;
      b_row_r    <= q_row;
      b_e1_col_r <= q_e1_col;
      b_e1_row_r <= q_e1_row;
      // Forward the column written at this edge by the cell that leaves.
      fwd_hit_r  <= b_valid_r && (q_col == b_col_r);
      fwd_data_r <= ram_wdata;
    end
    if (b_leave) begin
      p2_r <= p1_r;
      p1_r <= cur_vec;
    end
    if (emit_fire) begin
      out_code_r <= sel_code;
      out_col_r  <= POS_W'(sel_col);
      out_row_r  <= POS_W'(sel_row);
      out_done_r <= sel_done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_padded_code = out_code_r;
  assign out_cell_column = out_col_r;
  assign out_cell_row    = out_row_r;
  assign out_frame_done  = out_done_r;

endmodule
